### sv/ndfa_pkg.sv
// ----------------------------------------------------------------------------
// ndfa_pkg: shared types and constants of the digit frame animator
// request and result word layouts, kind and mode codes, code mapping
// ----------------------------------------------------------------------------
package ndfa_pkg;

	localparam int DIGIT_COUNT = 6;
	localparam int CHAR_SLOTS  = 6;
	localparam int LEN_W       = 3;
	localparam int CHAR_W      = 8;
	localparam int CODE_W      = 4;
	localparam int FRAME_W     = CHAR_SLOTS * CODE_W;

	// longest accepted request
	localparam logic [LEN_W-1:0] LEN_LIMIT =
		LEN_W'((DIGIT_COUNT < CHAR_SLOTS) ? DIGIT_COUNT : CHAR_SLOTS);

	localparam logic MODE_REQUEST = 1'b0;
	localparam logic MODE_TICK    = 1'b1;

	localparam logic [1:0] KIND_IMMEDIATE = 2'd0;
	localparam logic [1:0] KIND_SCROLL    = 2'd1;
	localparam logic [1:0] KIND_FLIP      = 2'd2;

	localparam logic [CODE_W-1:0] BLANK_CODE = 4'h a;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

	typedef logic [CHAR_W-1:0] char_t;

	typedef struct packed {
		logic              mode;
		logic [1:0]        anim_kind;
		logic [LEN_W-1:0]  text_length;
		char_t             char_0;
		char_t             char_1;
		char_t             char_2;
		char_t             char_3;
		char_t             char_4;
		char_t             char_5;
	} req_word_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame_word;
		logic               latch_each_bit;
		logic               animation_busy;
	} res_word_t;

	// ascii digit to its code, anything else blanks
	function automatic logic [CODE_W-1:0] char_code(input char_t c);
		logic [CHAR_W-1:0] d;
		d = c - CHAR_ZERO;
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			char_code = d[CODE_W-1:0];
		end else begin
			char_code = BLANK_CODE;
		end
	endfunction

endpackage

### sv/nixie_digit_frame_animator.sv
// ----------------------------------------------------------------------------
// nixie_digit_frame_animator: text to packed digit frames with flip animation
// stores the shown text, steps it toward a flip target, emits frame words
// ----------------------------------------------------------------------------
//
//  channel | signals                    | direction | carries
//  --------+----------------------------+-----------+-----------------------
//  req     | req_valid req_ready req    | in        | request or tick word
//  res     | res_valid res_ready res    | out       | frame word and flags
//
// one word per cycle while the result is taken: a word waits in the input
// register while the compare-and-step units and nibble encoder settle, then
// its frame lands in the result register; state updates on the same edge
// a word with no result (idle tick, too-long request) is still consumed
// reset clears the input and result valid flags, shown text and flip state
// a stalled result holds the input register; the input register is refilled
// in the same cycle the result is taken
module nixie_digit_frame_animator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  ndfa_pkg::req_word_t req,
	output logic                res_valid,
	input  logic                res_ready,
	output ndfa_pkg::res_word_t res
);
	import ndfa_pkg::*;

	// input register
	logic      valid_s1;
	req_word_t word_s1;

	// result register
	logic      res_valid_q;
	res_word_t res_q;

	// display state
	char_t            shown_q  [CHAR_SLOTS];
	logic [LEN_W-1:0] shown_len_q;
	char_t            target_q [CHAR_SLOTS];   // no reset, read only while flipping
	logic [LEN_W-1:0] target_len_q;
	logic             flip_q;

	// handshake
	logic out_free;
	logic advance;

	// single pass logic
	char_t            chars      [CHAR_SLOTS];
	char_t            tgt        [CHAR_SLOTS];
	char_t            stepped    [CHAR_SLOTS];
	char_t            next_shown [CHAR_SLOTS];
	logic [LEN_W-1:0] tlen;
	logic [LEN_W-1:0] next_len;
	logic             tick;
	logic             too_long;
	logic             flip_req;
	logic             do_step;
	logic             plain;
	logic             emit;
	logic             neq_any;
	logic             next_flip;
	logic [FRAME_W-1:0] frame;

	assign out_free  = !res_valid_q || res_ready;
	assign advance   = valid_s1 && out_free;
	assign req_ready = !valid_s1 || out_free;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		chars[0] = word_s1.char_0;
		chars[1] = word_s1.char_1;
		chars[2] = word_s1.char_2;
		chars[3] = word_s1.char_3;
		chars[4] = word_s1.char_4;
		chars[5] = word_s1.char_5;

		tick     = (word_s1.mode == MODE_TICK);
		too_long = (word_s1.text_length > LEN_LIMIT);
		// flip on empty text falls back to a plain store
		flip_req = !tick && !too_long && (word_s1.anim_kind == KIND_FLIP)
			&& (shown_len_q != '0);
		do_step  = tick ? flip_q : flip_req;
		plain    = !tick && !too_long && !flip_req;
		emit     = tick ? flip_q : !too_long;

		tlen = flip_req ? word_s1.text_length : target_len_q;

		// one step toward the target on every position below the target length
		neq_any = 1'b0;
		for (int i = 0; i < CHAR_SLOTS; i++) begin
			tgt[i]     = flip_req ? chars[i] : target_q[i];
			stepped[i] = shown_q[i];
			if (LEN_W'(i) < tlen) begin
				if (shown_q[i] < tgt[i]) begin
					stepped[i] = shown_q[i] + 8'd1;
					neq_any    = 1'b1;
				end else if (shown_q[i] > tgt[i]) begin
					stepped[i] = shown_q[i] - 8'd1;
					neq_any    = 1'b1;
				end
			end
		end

		for (int i = 0; i < CHAR_SLOTS; i++) begin
			if (plain) begin
				next_shown[i] = (LEN_W'(i) < word_s1.text_length) ? chars[i] : '0;
			end else if (do_step) begin
				next_shown[i] = stepped[i];
			end else begin
				next_shown[i] = shown_q[i];
			end
		end

		// flip keeps the longer of old and new length
		if (plain) begin
			next_len = word_s1.text_length;
		end else if (flip_req && word_s1.text_length > shown_len_q) begin
			next_len = word_s1.text_length;
		end else begin
			next_len = shown_len_q;
		end

		if (plain) begin
			next_flip = 1'b0;
		end else if (do_step) begin
			next_flip = neq_any;
		end else begin
			next_flip = flip_q;
		end

		// right-aligned nibble pack, last shown character lowest
		frame = '0;
		for (int i = 0; i < CHAR_SLOTS; i++) begin
			if (LEN_W'(i) < next_len) begin
				frame = {frame[FRAME_W-CODE_W-1:0], char_code(next_shown[i])};
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			word_s1 <= req;
		end
	end

	// display state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHAR_SLOTS; i++) begin
				shown_q[i] <= '0;
			end
			shown_len_q  <= '0;
			target_len_q <= '0;
			flip_q       <= 1'b0;
		end else if (advance) begin
			for (int i = 0; i < CHAR_SLOTS; i++) begin
				shown_q[i] <= next_shown[i];
			end
			shown_len_q <= next_len;
			flip_q      <= next_flip;
			if (flip_req) begin
				target_len_q <= word_s1.text_length;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && flip_req) begin
			for (int i = 0; i < CHAR_SLOTS; i++) begin
				target_q[i] <= chars[i];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= emit;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q.frame_word     <= frame;
			res_q.latch_each_bit <= plain && (word_s1.anim_kind == KIND_SCROLL);
			res_q.animation_busy <= do_step && neq_any;
		end
	end

	// a busy frame waiting at the output means the flip is still running
	a_busy_flip: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.animation_busy |-> flip_q)
		else $error("busy frame without running flip");

	// scroll frames come only from plain stores, never from a flip step
	a_latch_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(res_q.latch_each_bit && res_q.animation_busy))
		else $error("latch and busy both set");

	// shown length never passes the accepted limit
	a_len_limit: assert property (@(posedge clk) disable iff (!arst_n)
		shown_len_q <= LEN_LIMIT)
		else $error("shown length beyond limit");

	// state moves only when a word passes the input register
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(flip_q) && $stable(shown_len_q))
		else $error("state changed without a word");

endmodule
